// ===== rtl/core/rsq_pkg.sv =====
// Shared types and constants of the range sample qualifier.
`default_nettype none
package rsq_pkg;

  // Field widths.
  localparam int unsigned CAP_W    = 13;
  localparam int unsigned CM_W     = 10;
  localparam int unsigned MISS_W   = 8;
  localparam int unsigned STALE_W  = 16;
  localparam int unsigned RANGE_W  = 16;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned CFG_IDX_W = 2;

  // Register reset values.
  localparam logic [CAP_W-1:0]   CAP_MM_RESET     = 13'd1000;
  localparam logic [CM_W-1:0]    MAX_CM_RESET     = 10'd80;
  localparam logic [MISS_W-1:0]  FAIL_LIMIT_RESET = 8'd3;
  localparam logic [STALE_W-1:0] STALE_MS_RESET   = 16'd150;

  // Divide by ten through a reciprocal: (mm * 6554) >> 16 is exact for mm < 8192.
  localparam logic [12:0] CM_RECIP = 13'd6554;
  localparam int unsigned RECIP_SHIFT = 16;

  localparam logic [MISS_W-1:0] MISS_SAT = 8'd255;
  localparam logic [CM_W-1:0]   CM_FLOOR = 10'd1;

  // Poll status codes.
  localparam logic [1:0] POLL_NONE = 2'd0;
  localparam logic [1:0] POLL_NEW  = 2'd1;
  localparam int unsigned POLL_ERR_BIT = 1;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CAP_MM     = 2'd0,
    REG_MAX_CM     = 2'd1,
    REG_FAIL_LIMIT = 2'd2,
    REG_STALE_MS   = 2'd3
  } reg_idx_t;

  // Configuration as seen by the front and the back.
  typedef struct packed {
    logic [CAP_W-1:0]   cap_mm;
    logic [CM_W-1:0]    max_cm;
    logic [MISS_W-1:0]  fail_limit;
    logic [STALE_W-1:0] stale_ms;
  } cfg_t;

  // What the back has to do with one poll.
  typedef enum logic [1:0] {
    CMD_IDLE   = 2'd0,
    CMD_FRESH  = 2'd1,
    CMD_ERROR  = 2'd2,
    CMD_EXPIRE = 2'd3
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [CAP_W-1:0]  mm;
    logic [CM_W-1:0]   cm;
    logic [TIME_W-1:0] now_ms;
  } cmd_t;

endpackage
`default_nettype wire

// ===== rtl/core/rsq_front.sv =====
// Front stage: accepts polls, classifies them and converts the range.
`default_nettype none
module rsq_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire rsq_pkg::cfg_t                 cfg,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          sensor_alive,
  input  wire logic [1:0]                    poll_status,
  input  wire logic [rsq_pkg::RANGE_W-1:0]   range_mm,
  input  wire logic [rsq_pkg::TIME_W-1:0]    now_ms,
  output logic                               cmd_valid,
  input  wire logic                          cmd_ready,
  output rsq_pkg::cmd_t                      cmd
);

  logic [rsq_pkg::CAP_W-1:0]         mm_cap;
  logic [2*rsq_pkg::CAP_W-1:0]       prod;
  logic [rsq_pkg::CM_W-1:0]          cm_raw;
  logic [rsq_pkg::CM_W-1:0]          cm_clamp;
  rsq_pkg::cmd_t                     cmd_next;

  assign in_ready = !cmd_valid || cmd_ready;

  // Cap the range, convert to cm, clamp and floor.
  always_comb begin
    if (range_mm > {{(rsq_pkg::RANGE_W-rsq_pkg::CAP_W){1'b0}}, cfg.cap_mm}) begin
      mm_cap = cfg.cap_mm;
    end else begin
      mm_cap = range_mm[rsq_pkg::CAP_W-1:0];
    end
    prod     = mm_cap * rsq_pkg::CM_RECIP;
    cm_raw   = prod[rsq_pkg::RECIP_SHIFT +: rsq_pkg::CM_W];
    cm_clamp = (cm_raw > cfg.max_cm) ? cfg.max_cm : cm_raw;
  end

  // Classify the poll.
  always_comb begin
    cmd_next.mm     = mm_cap;
    cmd_next.cm     = (cm_clamp == '0) ? rsq_pkg::CM_FLOOR : cm_clamp;
    cmd_next.now_ms = now_ms;
    priority if (!sensor_alive) begin
      cmd_next.kind = rsq_pkg::CMD_EXPIRE;
    end else if (poll_status == rsq_pkg::POLL_NEW) begin
      cmd_next.kind = rsq_pkg::CMD_FRESH;
    end else if (poll_status[rsq_pkg::POLL_ERR_BIT]) begin
      cmd_next.kind = rsq_pkg::CMD_ERROR;
    end else begin
      cmd_next.kind = rsq_pkg::CMD_IDLE;
    end
  end

  // Command register.
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      cmd_valid <= 1'b1;
    end else if (cmd_ready) begin
      cmd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd <= cmd_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/rsq_queue.sv =====
// Two-entry command queue between the front and the back.
`default_nettype none
module rsq_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire rsq_pkg::cmd_t  in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output rsq_pkg::cmd_t       out_data
);

  rsq_pkg::cmd_t mem [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;
  logic          push;
  logic          pop;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_data  = mem[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_data;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/rsq_back.sv =====
// Back stage: channel state, history, median and the result register.
`default_nettype none
module rsq_back #(
  parameter int unsigned WINDOW = 3
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire rsq_pkg::cfg_t                cfg,
  input  wire logic                         cmd_valid,
  output logic                              cmd_ready,
  input  wire rsq_pkg::cmd_t                cmd,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [rsq_pkg::CAP_W-1:0]         distance_mm,
  output logic [rsq_pkg::CM_W-1:0]          median_cm
);

  localparam int unsigned RW = $clog2(WINDOW + 1);
  localparam logic [RW-1:0] MID = RW'(WINDOW / 2);

  logic [rsq_pkg::CM_W-1:0]   history      [WINDOW];
  logic [rsq_pkg::CM_W-1:0]   history_next [WINDOW];
  logic [RW-1:0]              rank         [WINDOW];
  logic [rsq_pkg::MISS_W-1:0] miss_count;
  logic [rsq_pkg::MISS_W-1:0] miss_count_next;
  logic [rsq_pkg::MISS_W-1:0] miss_inc;
  logic [rsq_pkg::TIME_W-1:0] last_fresh_ms;
  logic [rsq_pkg::TIME_W-1:0] last_fresh_ms_next;
  logic [rsq_pkg::TIME_W-1:0] age;
  logic [rsq_pkg::CAP_W-1:0]  held_mm;
  logic [rsq_pkg::CAP_W-1:0]  held_mm_next;
  logic [rsq_pkg::CM_W-1:0]   median_next;
  logic                       expire;
  logic                       pop;

  assign pop       = cmd_valid && cmd_ready;
  assign cmd_ready = !out_valid || out_ready;
  assign miss_inc  = miss_count + 1'b1;
  assign age       = cmd.now_ms - last_fresh_ms;

  // Next channel state for the command at the head of the queue.
  always_comb begin
    miss_count_next    = miss_count;
    last_fresh_ms_next = last_fresh_ms;
    held_mm_next       = held_mm;
    expire             = 1'b0;
    for (int i = 0; i < WINDOW; i++) begin
      history_next[i] = history[i];
    end
    unique case (cmd.kind)
      rsq_pkg::CMD_EXPIRE: begin
        expire = 1'b1;
      end
      rsq_pkg::CMD_FRESH: begin
        miss_count_next    = '0;
        last_fresh_ms_next = cmd.now_ms;
        held_mm_next       = cmd.mm;
        history_next[0]    = cmd.cm;
        for (int i = 1; i < WINDOW; i++) begin
          history_next[i] = history[i-1];
        end
      end
      rsq_pkg::CMD_ERROR: begin
        if (miss_count != rsq_pkg::MISS_SAT) begin
          miss_count_next = miss_inc;
          expire          = (miss_inc >= cfg.fail_limit);
        end
      end
      default: begin
        expire = (age > {{(rsq_pkg::TIME_W-rsq_pkg::STALE_W){1'b0}}, cfg.stale_ms});
      end
    endcase
    // Expiry overrides the held distance and the whole history.
    if (expire) begin
      held_mm_next = cfg.cap_mm;
      for (int i = 0; i < WINDOW; i++) begin
        history_next[i] = cfg.max_cm;
      end
    end
  end

  // Median by rank: ties are broken by position so every rank is unique.
  always_comb begin
    for (int i = 0; i < WINDOW; i++) begin
      rank[i] = '0;
      for (int j = 0; j < WINDOW; j++) begin
        if (j != i && (history_next[j] < history_next[i] ||
                       (history_next[j] == history_next[i] && j < i))) begin
          rank[i] = rank[i] + 1'b1;
        end
      end
    end
    median_next = '0;
    for (int i = 0; i < WINDOW; i++) begin
      if (rank[i] == MID) begin
        median_next = history_next[i];
      end
    end
  end

  // Channel state.
  always_ff @(posedge clk) begin
    if (rst) begin
      miss_count    <= '0;
      last_fresh_ms <= '0;
      held_mm       <= rsq_pkg::CAP_MM_RESET;
      for (int i = 0; i < WINDOW; i++) begin
        history[i] <= rsq_pkg::MAX_CM_RESET;
      end
    end else if (pop) begin
      miss_count    <= miss_count_next;
      last_fresh_ms <= last_fresh_ms_next;
      held_mm       <= held_mm_next;
      for (int i = 0; i < WINDOW; i++) begin
        history[i] <= history_next[i];
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      distance_mm <= held_mm_next;
      median_cm   <= median_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/range_sample_qualifier_core.sv =====
// Top level of the range sample qualifier: configuration registers and stages.
//
//   channel   direction  beat fields (lowest bit first)
//   s_axis    in         tdata: range_mm, now_ms; tuser: sensor_alive, poll_status
//   m_axis    out        tdata: distance_mm, median_cm
//   cfg       in         cfg_we, cfg_index, cfg_data (write only)
//
// One poll per cycle sustained while m_axis does not stall; a beat's result passes through
// the front command register, the queue and the back result register in that order.
// Synchronous reset loads the register defaults and the channel's expired state.
// A stall on m_axis fills the two-entry queue before s_axis_tready drops.
`default_nettype none
module range_sample_qualifier_core #(
  parameter int unsigned WINDOW = 3
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  wire logic [47:0]                       s_axis_tdata,  // range_mm, now_ms
  input  wire logic [2:0]                        s_axis_tuser,  // sensor_alive, poll_status
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  output logic [23:0]                            m_axis_tdata,  // distance_mm, median_cm
  input  wire logic                              cfg_we,
  input  wire logic [rsq_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [rsq_pkg::CFG_W-1:0]         cfg_data
);

  rsq_pkg::cfg_t               cfg;
  rsq_pkg::cmd_t               front_cmd;
  rsq_pkg::cmd_t               queue_cmd;
  logic                        front_valid;
  logic                        front_ready;
  logic                        queue_valid;
  logic                        queue_ready;
  logic [rsq_pkg::CAP_W-1:0]   distance_mm;
  logic [rsq_pkg::CM_W-1:0]    median_cm;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cap_mm     <= rsq_pkg::CAP_MM_RESET;
      cfg.max_cm     <= rsq_pkg::MAX_CM_RESET;
      cfg.fail_limit <= rsq_pkg::FAIL_LIMIT_RESET;
      cfg.stale_ms   <= rsq_pkg::STALE_MS_RESET;
    end else if (cfg_we) begin
      unique case (rsq_pkg::reg_idx_t'(cfg_index))
        rsq_pkg::REG_CAP_MM:     cfg.cap_mm     <= cfg_data[rsq_pkg::CAP_W-1:0];
        rsq_pkg::REG_MAX_CM:     cfg.max_cm     <= cfg_data[rsq_pkg::CM_W-1:0];
        rsq_pkg::REG_FAIL_LIMIT: cfg.fail_limit <= cfg_data[rsq_pkg::MISS_W-1:0];
        rsq_pkg::REG_STALE_MS:   cfg.stale_ms   <= cfg_data[rsq_pkg::STALE_W-1:0];
        default: ;
      endcase
    end
  end

  rsq_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_valid     (s_axis_tvalid),
    .in_ready     (s_axis_tready),
    .sensor_alive (s_axis_tuser[0]),
    .poll_status  (s_axis_tuser[2:1]),
    .range_mm     (s_axis_tdata[15:0]),
    .now_ms       (s_axis_tdata[47:16]),
    .cmd_valid    (front_valid),
    .cmd_ready    (front_ready),
    .cmd          (front_cmd)
  );

  rsq_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .in_data   (front_cmd),
    .out_valid (queue_valid),
    .out_ready (queue_ready),
    .out_data  (queue_cmd)
  );

  rsq_back #(
    .WINDOW (WINDOW)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .cmd_valid   (queue_valid),
    .cmd_ready   (queue_ready),
    .cmd         (queue_cmd),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .distance_mm (distance_mm),
    .median_cm   (median_cm)
  );

  assign m_axis_tdata = {1'b0, median_cm, distance_mm};

endmodule
`default_nettype wire

// ===== bench/range_sample_qualifier_core_tb.sv =====
// Self-checking testbench for the range sample qualifier core with a built-in channel predictor.
`timescale 1ns / 100ps

module range_sample_qualifier_core_tb;

  // Bus error codes; any status with the error bit set counts as an error.
  localparam logic [1:0] POLL_ERR     = 2'd2;
  localparam logic [1:0] POLL_ERR_ALT = 2'd3;

  typedef struct {
    logic        alive;
    logic [1:0]  status;
    logic [15:0] range_mm;
    logic [31:0] now_ms;
  } poll_t;

  typedef struct {
    logic [12:0] distance_mm;
    logic [9:0]  median_cm;
  } reading_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;  // range_mm, now_ms
  logic [2:0]  s_axis_tuser = '0;  // sensor_alive, poll_status
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;       // distance_mm, median_cm
  logic        cfg_we = 1'b0;
  logic [rsq_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [rsq_pkg::CFG_W-1:0]     cfg_data = '0;

  range_sample_qualifier_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // Clock and the single reset at the start of the run.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  // Shadow copy of the configuration registers.
  logic [12:0] cfg_cap   = rsq_pkg::CAP_MM_RESET;
  logic [9:0]  cfg_max_cm = rsq_pkg::MAX_CM_RESET;
  logic [7:0]  cfg_fail  = rsq_pkg::FAIL_LIMIT_RESET;
  logic [15:0] cfg_stale = rsq_pkg::STALE_MS_RESET;

  // Predicted channel state.
  logic [9:0]  cm_hist [3] = '{rsq_pkg::MAX_CM_RESET, rsq_pkg::MAX_CM_RESET,
                               rsq_pkg::MAX_CM_RESET};
  logic [7:0]  miss_count = '0;
  logic [31:0] last_fresh_ms = '0;
  logic [12:0] held_mm = rsq_pkg::CAP_MM_RESET;

  poll_t       pending_polls [$];
  reading_t    readings_due [$];
  int unsigned polls_queued = 0;
  int unsigned polls_taken = 0;
  int unsigned mismatches = 0;
  logic        poll_taken = 1'b0;

  // Idle behavior of each side: 0 never idles, 1 light, 2 heavy.
  int unsigned in_mode = 1;
  int unsigned out_mode = 1;
  int unsigned in_gap = 0;
  int unsigned out_stall = 0;

  // Stimulus time base.
  logic [31:0] gen_now = '0;
  logic [31:0] gen_fresh = '0;

  function automatic void expire_channel_state();
    held_mm = cfg_cap;
    for (int i = 0; i < 3; i++) cm_hist[i] = cfg_max_cm;
  endfunction

  function automatic logic [9:0] median_of_three(input logic [9:0] a, b, c);
    logic [9:0] lo, hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    if (c < lo) return lo;
    if (c > hi) return hi;
    return c;
  endfunction

  // Applies one poll to the predicted state and returns the expected reading.
  function automatic reading_t qualify_poll(input poll_t p);
    reading_t r;
    logic [15:0] mm;
    logic [9:0]  cm;
    if (!p.alive) begin
      expire_channel_state();
    end else if (p.status == rsq_pkg::POLL_NEW) begin
      miss_count = '0;
      last_fresh_ms = p.now_ms;
      mm = (p.range_mm > 16'(cfg_cap)) ? 16'(cfg_cap) : p.range_mm;
      held_mm = mm[12:0];
      cm = 10'(mm / 16'd10);
      if (cm > cfg_max_cm) cm = cfg_max_cm;
      if (cm == '0) cm = rsq_pkg::CM_FLOOR;
      cm_hist[2] = cm_hist[1];
      cm_hist[1] = cm_hist[0];
      cm_hist[0] = cm;
    end else if (p.status[rsq_pkg::POLL_ERR_BIT]) begin
      // A saturated miss count neither counts nor expires.
      if (miss_count != rsq_pkg::MISS_SAT) begin
        miss_count = miss_count + 8'd1;
        if (miss_count >= cfg_fail) expire_channel_state();
      end
    end else if ((p.now_ms - last_fresh_ms) > 32'(cfg_stale)) begin
      expire_channel_state();
    end
    r.distance_mm = held_mm;
    r.median_cm = median_of_three(cm_hist[0], cm_hist[1], cm_hist[2]);
    return r;
  endfunction

  // Scoreboard: register writes, result checks and predictions on accepted beats.
  always @(posedge clk) begin
    poll_t    p;
    reading_t want;
    poll_taken <= !rst && s_axis_tvalid && s_axis_tready;
    if (!rst) begin
      if (cfg_we) begin
        case (rsq_pkg::reg_idx_t'(cfg_index))
          rsq_pkg::REG_CAP_MM:     cfg_cap = cfg_data[12:0];
          rsq_pkg::REG_MAX_CM:     cfg_max_cm = cfg_data[9:0];
          rsq_pkg::REG_FAIL_LIMIT: cfg_fail = cfg_data[7:0];
          rsq_pkg::REG_STALE_MS:   cfg_stale = cfg_data;
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (readings_due.size() == 0) begin
          $display("%0t: unexpected output beat, expected none actual %h", $time, m_axis_tdata);
          mismatches++;
        end else begin
          want = readings_due.pop_front();
          if (m_axis_tdata[12:0] !== want.distance_mm) begin
            $display("%0t: distance_mm expected %0d actual %0d", $time, want.distance_mm,
                     m_axis_tdata[12:0]);
            mismatches++;
          end
          if (m_axis_tdata[22:13] !== want.median_cm) begin
            $display("%0t: median_cm expected %0d actual %0d", $time, want.median_cm,
                     m_axis_tdata[22:13]);
            mismatches++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        p.alive = s_axis_tuser[0];
        p.status = s_axis_tuser[2:1];
        p.range_mm = s_axis_tdata[15:0];
        p.now_ms = s_axis_tdata[47:16];
        readings_due.push_back(qualify_poll(p));
        polls_taken++;
      end
    end
  end

  function automatic int unsigned pick_gap(input int unsigned mode);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (mode == 0) return 0;
    if (r < ((mode == 1) ? 70 : 30)) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Input driver: a new beat goes out after the previous one was taken and its gap has run out.
  always @(negedge clk) begin
    poll_t p;
    if (!rst && (!s_axis_tvalid || poll_taken)) begin
      if (in_gap > 0) begin
        s_axis_tvalid <= 1'b0;
        in_gap = in_gap - 1;
      end else if (pending_polls.size() != 0) begin
        p = pending_polls.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {p.now_ms, p.range_mm};
        s_axis_tuser <= {p.status, p.alive};
        in_gap = pick_gap(in_mode);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Output stalls: ready goes high between any two stalls.
  always @(negedge clk) begin
    if (out_stall > 0) begin
      m_axis_tready <= 1'b0;
      out_stall = out_stall - 1;
    end else begin
      m_axis_tready <= 1'b1;
      out_stall = pick_gap(out_mode);
    end
  end

  function automatic void queue_poll(input logic alive, input logic [1:0] status,
                                     input logic [15:0] range_mm, input logic [31:0] now_ms);
    poll_t p;
    p.alive = alive;
    p.status = status;
    p.range_mm = range_mm;
    p.now_ms = now_ms;
    pending_polls.push_back(p);
    polls_queued++;
  endfunction

  function automatic logic [15:0] pick_range();
    case ($urandom_range(0, 4))
      0: return 16'($urandom_range(0, 20));
      1: return 16'(cfg_cap) + 16'($urandom_range(0, 4)) - 16'd2;
      2: return 16'($urandom_range(0, 10 * cfg_max_cm + 20));
      3: return 16'($urandom_range(0, 16'hFFFF));
      default: return 16'($urandom_range(0, cfg_cap));
    endcase
  endfunction

  // Mostly well-formed poll sequences with random content, plus dead polls and noise.
  task automatic queue_random_polls(input int unsigned n);
    int unsigned made, len, pick;
    logic [31:0] step;
    made = 0;
    while (made < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        len = $urandom_range(1, 8);
        for (int k = 0; k < len; k++) begin
          gen_now = gen_now + 32'($urandom_range(0, 60));
          queue_poll(1'b1, rsq_pkg::POLL_NEW, pick_range(), gen_now);
          gen_fresh = gen_now;
        end
      end else if (pick < 65) begin
        // Quiet polls around the stale threshold.
        len = $urandom_range(1, 4);
        for (int k = 0; k < len; k++) begin
          case ($urandom_range(0, 3))
            0: step = 32'(cfg_stale);
            1: step = 32'(cfg_stale) + 32'd1;
            2: step = 32'($urandom_range(0, 2 * 32'(cfg_stale) + 2));
            default: step = 32'($urandom);
          endcase
          gen_now = gen_fresh + step;
          queue_poll(1'b1, rsq_pkg::POLL_NONE, 16'($urandom_range(0, 16'hFFFF)), gen_now);
        end
      end else if (pick < 80) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, cfg_fail + 3)
                                          : $urandom_range(1, 3);
        for (int k = 0; k < len; k++) begin
          gen_now = gen_now + 32'($urandom_range(0, 30));
          queue_poll(1'b1, $urandom_range(0, 1) ? POLL_ERR : POLL_ERR_ALT,
                     16'($urandom_range(0, 16'hFFFF)), gen_now);
        end
      end else if (pick < 88) begin
        len = 1;
        queue_poll(1'b0, 2'($urandom_range(0, 3)), 16'($urandom_range(0, 16'hFFFF)), gen_now);
      end else begin
        len = 1;
        queue_poll(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                   16'($urandom_range(0, 16'hFFFF)), 32'($urandom));
      end
      made += len;
    end
  endtask

  // Waits until every queued poll was taken and every reading arrived, then lets the pipe drain.
  task automatic settle();
    while (polls_taken != polls_queued || readings_due.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic program_regs(input logic [15:0] cap, max_cm, fail, stale);
    logic [15:0] vals [4];
    vals = '{cap, max_cm, fail, stale};
    for (int i = 0; i < 4; i++) begin
      @(negedge clk);
      cfg_we <= 1'b1;
      cfg_index <= rsq_pkg::reg_idx_t'(i);
      cfg_data <= vals[i];
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic pick_modes();
    in_mode = $urandom_range(0, 2);
    out_mode = $urandom_range(0, 2);
  endtask

  // Main sequence: directed polls, then random phases under several register settings.
  initial begin
    while (rst) @(negedge clk);
    @(negedge clk);

    // Floors, caps, the stale threshold, error expiry, a dead sensor and time wrap.
    queue_poll(1'b1, rsq_pkg::POLL_NEW, 16'd0, 32'd5);
    queue_poll(1'b1, rsq_pkg::POLL_NEW, 16'hFFFF, 32'd10);
    queue_poll(1'b1, rsq_pkg::POLL_NEW, 16'd9, 32'd20);
    queue_poll(1'b1, rsq_pkg::POLL_NEW, 16'd555, 32'd30);
    queue_poll(1'b1, rsq_pkg::POLL_NONE, 16'hFFFF, 32'd180);
    queue_poll(1'b1, rsq_pkg::POLL_NONE, 16'd0, 32'd181);
    queue_poll(1'b1, POLL_ERR, 16'd0, 32'd190);
    queue_poll(1'b1, POLL_ERR_ALT, 16'd77, 32'd191);
    queue_poll(1'b1, POLL_ERR, 16'd0, 32'd192);
    queue_poll(1'b1, rsq_pkg::POLL_NEW, 16'd123, 32'd200);
    queue_poll(1'b0, rsq_pkg::POLL_NEW, 16'd4321, 32'd210);
    queue_poll(1'b0, POLL_ERR_ALT, 16'd0, 32'd220);
    queue_poll(1'b1, rsq_pkg::POLL_NONE, 16'd0, 32'hFFFF_FFF0);
    queue_poll(1'b1, rsq_pkg::POLL_NEW, 16'd8000, 32'hFFFF_FFF0);
    queue_poll(1'b1, rsq_pkg::POLL_NEW, 16'd250, 32'hFFFF_FFFA);
    queue_poll(1'b1, rsq_pkg::POLL_NONE, 16'd0, 32'h0000_0010);
    queue_poll(1'b1, rsq_pkg::POLL_NONE, 16'h8000, 32'h0000_0090);
    queue_poll(1'b1, rsq_pkg::POLL_NONE, 16'd0, 32'h0000_0091);
    queue_poll(1'b1, POLL_ERR, 16'd0, 32'h0000_00A0);
    queue_poll(1'b1, rsq_pkg::POLL_NEW, 16'hFFFF, 32'h0000_00B0);
    queue_poll(1'b0, rsq_pkg::POLL_NONE, 16'hFFFF, 32'hFFFF_FFFF);
    gen_now = 32'h100;
    gen_fresh = 32'h100;
    settle();

    pick_modes();
    queue_random_polls(170);
    settle();

    // All registers at their widest; a long error run saturates the miss count.
    program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    pick_modes();
    gen_now = gen_now + 32'd10;
    queue_poll(1'b1, rsq_pkg::POLL_NEW, 16'd3000, gen_now);
    gen_fresh = gen_now;
    for (int k = 0; k < 260; k++)
      queue_poll(1'b1, (k % 2 == 0) ? POLL_ERR : POLL_ERR_ALT, 16'd0, gen_now);
    queue_poll(1'b1, rsq_pkg::POLL_NONE, 16'd0, gen_now);
    queue_poll(1'b1, rsq_pkg::POLL_NEW, 16'd7000, gen_now);
    queue_random_polls(170);
    settle();

    // Zero everywhere once masked: every error expires, every fresh entry floors to one.
    program_regs(16'hE000, 16'hFC00, 16'hFF00, 16'h0000);
    pick_modes();
    queue_random_polls(170);
    settle();

    program_regs(16'd1, 16'd1, 16'd1, 16'd1);
    pick_modes();
    queue_random_polls(170);
    settle();

    // Random values with junk above each register's width; time wraps during this phase.
    program_regs(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    pick_modes();
    gen_now = 32'hFFFF_FE00;
    gen_fresh = gen_now;
    queue_random_polls(170);
    settle();

    program_regs(16'd4000, 16'd250, 16'd5, 16'd300);
    in_mode = 0;
    out_mode = 0;
    queue_random_polls(150);
    settle();

    program_regs(16'($urandom_range(1, 8191)), 16'($urandom_range(1, 819)),
                 16'($urandom_range(1, 255)), 16'($urandom_range(0, 65535)));
    pick_modes();
    queue_random_polls(170);
    settle();

    if (mismatches == 0) begin
      $display("range_sample_qualifier_core test passed");
    end else begin
      $display("range_sample_qualifier_core test failed");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #20000000;
    $display("range_sample_qualifier_core test failed");
    $finish;
  end

endmodule
